// ----- sv/cvd_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and helpers of the chunked varint decoder.
package cvd_pkg;

    localparam int BYTE_W        = 8;
    localparam int VALUE_W_DEF   = 16;
    localparam int OUT_VALUE_W   = 16;
    localparam int MAX_RES       = 4;
    localparam int RES_CNT_W     = $clog2(MAX_RES + 1);
    localparam int CARRY_W       = 7;
    localparam int CARRY_CNT_W   = 3;
    localparam int NIB_W         = 4;
    localparam int BITS_W        = CARRY_W + BYTE_W;
    localparam logic [NIB_W-1:0] CHUNK_MIN = 4'd2;
    localparam logic [NIB_W-1:0] CHUNK_MAX = 4'd8;
    localparam logic [NIB_W-1:0] BYTE_BITS = 4'd8;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              final_byte;
    } t_in_item;

    typedef struct packed {
        logic [OUT_VALUE_W-1:0] value;
        logic                   cut_short;
        logic                   bad_header;
    } t_result;

    function automatic logic [BYTE_W-1:0] low_mask(input logic [NIB_W-1:0] n);
        logic [BYTE_W:0] m;
        m = (9'd1 << n) - 9'd1;
        return m[BYTE_W-1:0];
    endfunction

endpackage

// ----- sv/cvd_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for byte input and value output beats.
interface cvd_in_if import cvd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              final_byte;

    modport source (output valid, data_byte, first_byte, final_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, final_byte, output ready);
endinterface

interface cvd_out_if import cvd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OUT_VALUE_W-1:0] value;
    logic                   run_last;
    logic                   cut_short;
    logic                   bad_header;

    modport source (output valid, value, run_last, cut_short, bad_header, input ready);
    modport sink   (input valid, value, run_last, cut_short, bad_header, output ready);
endinterface

// ----- sv/cvd_core.sv -----
`timescale 1ns / 1ps
// Stream state and single-pass chunk decode of one registered byte.
module cvd_core import cvd_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  t_in_item             i_item,
    output t_result              o_res [MAX_RES],
    output logic [RES_CNT_W-1:0] o_res_cnt
);

    logic [NIB_W-1:0]       r_chunk_len,   n_chunk_len;
    logic [NIB_W-1:0]       r_pad_count,   n_pad_count;
    logic [CARRY_W-1:0]     r_carry_bits,  n_carry_bits;
    logic [CARRY_CNT_W-1:0] r_carry_count, n_carry_count;
    logic [VALUE_WIDTH-1:0] r_acc,         n_acc;
    logic                   r_value_open,  n_value_open;
    logic                   r_stream_active, n_stream_active;

    always_comb begin
        logic [NIB_W-1:0]       hdr_len;
        logic [NIB_W-1:0]       usable;
        logic [BITS_W-1:0]      bits;
        logic [NIB_W-1:0]       cnt;
        logic [NIB_W-1:0]       len;
        logic [BYTE_W-1:0]      chunk;
        logic                   more;
        logic [CARRY_W-1:0]     payload;
        logic [VALUE_WIDTH-1:0] acc;
        logic                   opn;
        logic [RES_CNT_W-1:0]   n;

        hdr_len = i_item.data_byte[NIB_W-1:0];
        usable  = BYTE_BITS;
        bits    = '0;
        cnt     = '0;
        len     = r_chunk_len;
        chunk   = '0;
        more    = 1'b0;
        payload = '0;
        acc     = r_acc;
        opn     = r_value_open;
        n       = '0;
        for (int j = 0; j < MAX_RES; j++) begin
            o_res[j] = '0;
        end

        n_chunk_len     = r_chunk_len;
        n_pad_count     = r_pad_count;
        n_carry_bits    = r_carry_bits;
        n_carry_count   = r_carry_count;
        n_acc           = r_acc;
        n_value_open    = r_value_open;
        n_stream_active = r_stream_active;

        if (i_fire && i_item.first_byte) begin
            n_chunk_len     = '0;
            n_pad_count     = '0;
            n_carry_bits    = '0;
            n_carry_count   = '0;
            n_acc           = '0;
            n_value_open    = 1'b0;
            n_stream_active = 1'b0;
            if (hdr_len < CHUNK_MIN || hdr_len > CHUNK_MAX) begin
                o_res[0].bad_header = 1'b1;
                n = RES_CNT_W'(1);
            end else if (!i_item.final_byte) begin
                n_chunk_len     = hdr_len;
                n_pad_count     = i_item.data_byte[BYTE_W-1:NIB_W];
                n_stream_active = 1'b1;
            end
        end else if (i_fire && r_stream_active) begin
            if (i_item.final_byte) begin
                usable = (r_pad_count >= BYTE_BITS) ? '0 : BYTE_BITS - r_pad_count;
            end
            bits = (BITS_W'(r_carry_bits) << usable)
                 | BITS_W'(i_item.data_byte >> (BYTE_BITS - usable));
            cnt  = NIB_W'(r_carry_count) + usable;

            for (int k = 0; k < MAX_RES; k++) begin
                if (cnt >= len && len >= CHUNK_MIN) begin
                    chunk   = BYTE_W'(bits >> (cnt - len)) & low_mask(len);
                    more    = chunk[3'(len - 4'd1)];
                    payload = CARRY_W'(chunk & low_mask(len - 4'd1));
                    cnt     = cnt - len;
                    acc     = (acc << (len - 4'd1)) | VALUE_WIDTH'(payload);
                    opn     = 1'b1;
                    if (!more && n < RES_CNT_W'(MAX_RES)) begin
                        o_res[n[RES_CNT_W-2:0]].value = OUT_VALUE_W'(acc);
                        n   = n + RES_CNT_W'(1);
                        acc = '0;
                        opn = 1'b0;
                    end
                end
            end

            if (i_item.final_byte) begin
                if (opn && n < RES_CNT_W'(MAX_RES)) begin
                    o_res[n[RES_CNT_W-2:0]].value     = OUT_VALUE_W'(acc);
                    o_res[n[RES_CNT_W-2:0]].cut_short = 1'b1;
                    n = n + RES_CNT_W'(1);
                end
                n_chunk_len     = '0;
                n_pad_count     = '0;
                n_carry_bits    = '0;
                n_carry_count   = '0;
                n_acc           = '0;
                n_value_open    = 1'b0;
                n_stream_active = 1'b0;
            end else begin
                n_carry_count = CARRY_CNT_W'(cnt);
                n_carry_bits  = CARRY_W'(bits & ((BITS_W'(1) << cnt) - BITS_W'(1)));
                n_acc         = acc;
                n_value_open  = opn;
            end
        end
        o_res_cnt = n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_len     <= '0;
            r_pad_count     <= '0;
            r_carry_bits    <= '0;
            r_carry_count   <= '0;
            r_acc           <= '0;
            r_value_open    <= 1'b0;
            r_stream_active <= 1'b0;
        end else begin
            r_chunk_len     <= n_chunk_len;
            r_pad_count     <= n_pad_count;
            r_carry_bits    <= n_carry_bits;
            r_carry_count   <= n_carry_count;
            r_acc           <= n_acc;
            r_value_open    <= n_value_open;
            r_stream_active <= n_stream_active;
        end
    end

endmodule

// ----- sv/chunked_varint_decoder_top.sv -----
`timescale 1ns / 1ps
// Top level of the chunked varint decoder: input register, decode, result buffer.
// One byte is taken per beat and decoded in one pass from an input register into a
// result buffer of up to four values, which drains one value per output beat.
// A byte that yields no value or one value passes straight on, so bytes flow back to
// back while the output is ready; a byte that yields k values holds the buffer for k
// output beats, up to four with two-bit chunks. A byte passes the input register and
// then the result buffer before its first output beat. The accumulator width is
// VALUE_WIDTH; the value field carries its low 16 bits.
module chunked_varint_decoder_top import cvd_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_W_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cvd_in_if.sink     i_in,
    cvd_out_if.source  o_out
);

    logic                 r_in_v;
    t_in_item             r_in;
    t_result              r_res [MAX_RES];
    logic [RES_CNT_W-1:0] r_cnt;

    t_result              w_res [MAX_RES];
    logic [RES_CNT_W-1:0] w_res_cnt;
    logic                 w_take;
    logic                 w_fire;

    assign w_take = (r_cnt != '0) && o_out.ready;
    assign w_fire = r_in_v && ((r_cnt == '0) || ((r_cnt == RES_CNT_W'(1)) && o_out.ready));

    assign i_in.ready = !r_in_v || w_fire;

    cvd_core #(.VALUE_WIDTH(VALUE_WIDTH)) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_item    (r_in),
        .o_res     (w_res),
        .o_res_cnt (w_res_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_v <= 1'b1;
        end else if (w_fire) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.data_byte  <= i_in.data_byte;
            r_in.first_byte <= i_in.first_byte;
            r_in.final_byte <= i_in.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_fire) begin
            r_cnt <= w_res_cnt;
        end else if (w_take) begin
            r_cnt <= r_cnt - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end else if (w_take) begin
            for (int j = 0; j < MAX_RES - 1; j++) begin
                r_res[j] <= r_res[j+1];
            end
        end
    end

    assign o_out.valid      = (r_cnt != '0);
    assign o_out.value      = r_res[0].value;
    assign o_out.cut_short  = r_res[0].cut_short;
    assign o_out.bad_header = r_res[0].bad_header;
    assign o_out.run_last   = (r_cnt == RES_CNT_W'(1));

endmodule

// ----- sv/cvd_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the decoder output, bound to the top level.
module cvd_checker import cvd_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [OUT_VALUE_W-1:0] i_value,
    input logic                   i_run_last,
    input logic                   i_cut_short,
    input logic                   i_bad_header
);

    a_bad_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad_header |-> i_value == '0 && !i_cut_short && i_run_last)
        else $error("bad header beat carries value, cut flag or is not last");

    a_cut_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_cut_short |-> i_run_last)
        else $error("cut-off value is not the last beat of its byte");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_value)
            && $stable(i_run_last) && $stable(i_cut_short) && $stable(i_bad_header))
        else $error("stalled output beat changed");

endmodule

bind chunked_varint_decoder_top cvd_checker u_cvd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_value      (o_out.value),
    .i_run_last   (o_out.run_last),
    .i_cut_short  (o_out.cut_short),
    .i_bad_header (o_out.bad_header)
);

// ----- sim/tb_chunked_varint_decoder_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the chunked varint decoder: byte streams in, decoded values checked.
module tb_chunked_varint_decoder_top;
    import cvd_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int END_CYCLES   = 20;
    localparam int RANDOM_BYTES = 480;
    localparam int MAX_GAP      = 11;

    typedef struct packed {
        logic [OUT_VALUE_W-1:0] value;
        logic                   run_last;
        logic                   cut_short;
        logic                   bad_header;
    } t_decoded;

    class varint_tracker;
        logic [NIB_W-1:0]       chunk_len;
        logic [NIB_W-1:0]       pad_count;
        logic [CARRY_W-1:0]     carry_bits;
        logic [CARRY_CNT_W-1:0] carry_count;
        logic [OUT_VALUE_W-1:0] acc;
        bit                     value_open;
        bit                     stream_live;
        t_decoded               values_due[$];
        int                     mismatches;
        int                     values_checked;
        int                     cut_seen;
        int                     bad_seen;

        function void clear_stream();
            chunk_len   = '0;
            pad_count   = '0;
            carry_bits  = '0;
            carry_count = '0;
            acc         = '0;
            value_open  = 1'b0;
            stream_live = 1'b0;
        endfunction

        function int pending();
            return values_due.size();
        endfunction

        // Return 1 when the byte is decoded rather than ignored.
        function bit note_byte(input logic [BYTE_W-1:0] data, input bit first, input bit last);
            int unsigned len;
            int unsigned usable;
            int unsigned bits;
            int unsigned count;
            int unsigned chunk;
            int unsigned payload;
            t_decoded    made[$];
            if (first) begin
                len = data[NIB_W-1:0];
                clear_stream();
                if (len < CHUNK_MIN || len > CHUNK_MAX) begin
                    values_due.push_back('{'0, 1'b1, 1'b0, 1'b1});
                    return 1'b1;
                end
                if (!last) begin
                    chunk_len   = NIB_W'(len);
                    pad_count   = data[BYTE_W-1:NIB_W];
                    stream_live = 1'b1;
                end
                return 1'b1;
            end
            if (!stream_live)
                return 1'b0;
            usable = BYTE_BITS;
            if (last)
                usable = (pad_count >= BYTE_BITS) ? 0 : BYTE_BITS - pad_count;
            bits  = (int'(carry_bits) << usable) | (int'(data) >> (BYTE_BITS - usable));
            count = carry_count + usable;
            len   = chunk_len;
            while (count >= len) begin
                chunk   = (bits >> (count - len)) & ((1 << len) - 1);
                payload = chunk & ((1 << (len - 1)) - 1);
                count  -= len;
                acc        = OUT_VALUE_W'((acc << (len - 1)) | payload);
                value_open = 1'b1;
                if (((chunk >> (len - 1)) & 1) == 0) begin
                    made.push_back('{acc, 1'b0, 1'b0, 1'b0});
                    acc        = '0;
                    value_open = 1'b0;
                end
            end
            if (last) begin
                if (value_open)
                    made.push_back('{acc, 1'b0, 1'b1, 1'b0});
                clear_stream();
            end else begin
                carry_count = CARRY_CNT_W'(count);
                carry_bits  = CARRY_W'(bits & ((1 << count) - 1));
            end
            if (made.size() > 0)
                made[made.size()-1].run_last = 1'b1;
            foreach (made[i])
                values_due.push_back(made[i]);
            return 1'b1;
        endfunction

        function void check_value(input t_decoded got);
            t_decoded want;
            values_checked++;
            if (got.cut_short)
                cut_seen++;
            if (got.bad_header)
                bad_seen++;
            if (values_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: value=%h last=%b cut=%b bad=%b",
                             got.value, got.run_last, got.cut_short, got.bad_header);
                return;
            end
            want = values_due.pop_front();
            if (got.value !== want.value || got.run_last !== want.run_last ||
                got.cut_short !== want.cut_short || got.bad_header !== want.bad_header) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected value=%h last=%b cut=%b bad=%b,",
                              " got value=%h last=%b cut=%b bad=%b"},
                             want.value, want.run_last, want.cut_short, want.bad_header,
                             got.value, got.run_last, got.cut_short, got.bad_header);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cvd_in_if  in_if ();
    cvd_out_if out_if ();

    chunked_varint_decoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    varint_tracker tracker = new();

    bit in_calm;
    bit rx_calm;
    bit hold_req;
    bit hold_done;
    int bytes_sent;
    int bytes_decoded;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_chunked_varint_decoder_top NOT OK");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] data, input bit first, input bit last);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= data;
        in_if.first_byte <= first;
        in_if.final_byte <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        bytes_sent++;
        bytes_decoded += tracker.note_byte(data, first, last);
    endtask

    task automatic send_stream(input int len, input int pad, input int nbytes, input bit ends);
        send_byte({pad[NIB_W-1:0], len[NIB_W-1:0]}, 1'b1, ends && nbytes == 0);
        for (int i = 0; i < nbytes; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0, ends && i == nbytes - 1);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int stall_left;
        int hold_left;
        t_decoded got;
        stall_left = 0;
        hold_left  = 0;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.value, out_if.run_last, out_if.cut_short, out_if.bad_header};
                tracker.check_value(got);
                if ($urandom_range(0, 31) == 0)
                    rx_calm = !rx_calm;
                stall_left = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            out_if.ready <= (stall_left == 0 && hold_left == 0);
        end
    end

    initial begin
        int kind;
        int len;
        int pad;
        tracker.clear_stream();
        in_calm          = 1'b0;
        rx_calm          = 1'b0;
        hold_req         = 1'b0;
        hold_done        = 1'b0;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.data_byte  <= '0;
        in_if.first_byte <= 1'b0;
        in_if.final_byte <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bytes with no header, then bad headers
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hF1, 1'b1, 1'b1);
        send_byte(8'h39, 1'b1, 1'b0);
        send_byte(8'h0F, 1'b1, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        // empty stream
        send_byte(8'h34, 1'b1, 1'b1);
        // two-bit chunks, up to four values per byte
        send_byte(8'h02, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b1);
        // eight-bit chunks, value cut off by padding, partial chunk dropped
        send_byte(8'h38, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b1);
        // new header mid-stream
        send_byte(8'h05, 1'b1, 1'b0);
        send_byte(8'hC3, 1'b0, 1'b0);
        send_byte(8'h27, 1'b1, 1'b0);
        send_byte(8'h12, 1'b0, 1'b0);
        send_byte(8'hFE, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        // padding of a whole byte or more
        send_byte(8'hA3, 1'b1, 1'b0);
        send_byte(8'h6D, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hF6, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        drain();

        bytes_decoded = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            in_calm = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                len = $urandom_range(2, 8);
                pad = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 7);
                send_stream(len, pad, $urandom_range(0, 6), 1'b1);
            end else if (kind == 7) begin
                send_stream($urandom_range(2, 8), $urandom_range(0, 15),
                            $urandom_range(1, 4), 1'b0);
            end else if (kind == 8) begin
                len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) : $urandom_range(9, 15);
                send_byte({4'($urandom_range(0, 15)), 4'(len)}, 1'b1, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 2))
                    send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
            end else begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
            if (bytes_sent >= RANDOM_BYTES / 2 && !hold_done) begin
                drain();
                // stall the output long enough for the input to back up
                hold_done = 1'b1;
                hold_req  = 1'b1;
                in_calm   = 1'b1;
                repeat (3) send_stream(2, 0, 6, 1'b1);
                drain();
                hold_req = 1'b0;
            end
        end

        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        $display("covered %0d bytes (%0d decoded in the random part), %0d values checked",
                 bytes_sent, bytes_decoded, tracker.values_checked);
        $display("of which %0d cut off by padding and %0d bad headers; %0d mismatches",
                 tracker.cut_seen, tracker.bad_seen, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("tb_chunked_varint_decoder_top OK");
        end else begin
            $display("tb_chunked_varint_decoder_top NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/cvd_pkg.sv
sv/cvd_if.sv
sv/cvd_core.sv
sv/chunked_varint_decoder_top.sv
sv/cvd_checker.sv
sim/tb_chunked_varint_decoder_top.sv
